// ----- hdl/oscillator_trim_search_defines.svh -----
// Assertion macros for the oscillator trim search block.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef OSCILLATOR_TRIM_SEARCH_DEFINES_SVH
`define OSCILLATOR_TRIM_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define OTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oscillator trim search: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define OTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oscillator trim search: next-cycle check failed");

`endif

// ----- hdl/ots_pkg.sv -----
// Shared types and constants for the oscillator trim search block.
// No dependencies; the interfaces and all modules import this package.
package ots_pkg;

  localparam int TRIM_W     = 8;
  localparam int ERR_W      = 20;
  localparam int SUM_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every x below 2**26
  localparam logic [SUM_W-1:0] RECIP       = 24'hCCCCCD;
  localparam int               RECIP_SHIFT = 27;
  localparam int               PROD_W      = 2 * SUM_W;

  // Register reset values
  localparam logic              RST_SEARCH_DOWN  = 1'b0;
  localparam logic [TRIM_W-1:0] RST_START_TRIM   = 8'h80;
  localparam logic [ERR_W-1:0]  RST_COARSE_THR   = 20'd2500;
  localparam logic [ERR_W-1:0]  RST_JUMP_LIMIT   = 20'd3500;
  localparam logic [ERR_W-1:0]  RST_WORSEN_MARG  = 20'd50;
  localparam logic [TRIM_W-1:0] RST_RETRY_OFFSET = 8'd6;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_COARSE = 3'd1,
    PH_W1S    = 3'd2,
    PH_W1     = 3'd3,
    PH_W2S    = 3'd4,
    PH_W2     = 3'd5,
    PH_DONE   = 3'd6,
    PH_FAIL   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    STAT_SEARCH   = 2'd0,
    STAT_FINISHED = 2'd1,
    STAT_FAILED   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_DOWN  = 3'd0,
    CFG_START_TRIM   = 3'd1,
    CFG_COARSE_THR   = 3'd2,
    CFG_JUMP_LIMIT   = 3'd3,
    CFG_WORSEN_MARG  = 3'd4,
    CFG_RETRY_OFFSET = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              search_down;
    logic [TRIM_W-1:0] start_trim;
    logic [ERR_W-1:0]  coarse_threshold;
    logic [ERR_W-1:0]  jump_limit;
    logic [ERR_W-1:0]  worsen_margin;
    logic [TRIM_W-1:0] retry_offset;
  } cfg_t;

  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    logic              done_res;
    logic [ERR_W-1:0]  final_error;
    logic [1:0]        status;
  } res_t;

endpackage

// ----- hdl/ots_channels.sv -----
// Valid/ready channel interfaces for the oscillator trim search block.
// Depends on ots_pkg for field widths.
interface ots_in_if import ots_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SUM_W-1:0] meas_sum;

  modport source (output valid, cmd, meas_sum, input ready);
  modport sink   (input valid, cmd, meas_sum, output ready);
endinterface

interface ots_out_if import ots_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TRIM_W-1:0] trim;
  logic              done_res;
  logic [ERR_W-1:0]  final_error;
  logic [1:0]        status;

  modport source (output valid, trim, done_res, final_error, status, input ready);
  modport sink   (input valid, trim, done_res, final_error, status, output ready);
endinterface

// ----- hdl/oscillator_trim_search.sv -----
// Oscillator trim search: takes one word per clock unless the output side stalls
// it, and returns one result word per input word; the result is offered after
// passing the stage-one, stage-two and output registers.
// Stage one registers the incoming word, stage two holds |meas_sum| / 10 from a
// 24 x 24 reciprocal multiplier, stage three steps the search sequencer and
// registers the result. Each stage moves on its own ready, so bubbles close up
// and a new word is taken while a result still waits at the output. A start
// word (cmd 0) restarts the search at start_trim from any phase; measurement
// words step it. Write configuration only while the block is empty.
// Depends on ots_pkg, ots_channels, ots_err_unit, ots_search and the defines.
`include "oscillator_trim_search_defines.svh"

module oscillator_trim_search import ots_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ots_in_if.sink                in_ch,
  ots_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;

  // Pipeline occupancy and payload
  logic             s1_v_r, s2_v_r, out_v_r;
  logic             s1_cmd_r, s2_cmd_r;
  logic [SUM_W-1:0] s1_sum_r;
  res_t             out_res_r;

  logic             out_rdy, s2_rdy, s1_rdy;
  logic [ERR_W-1:0] err;
  res_t             res_nxt;

  // Configuration registers; writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_down      <= RST_SEARCH_DOWN;
      cfg_r.start_trim       <= RST_START_TRIM;
      cfg_r.coarse_threshold <= RST_COARSE_THR;
      cfg_r.jump_limit       <= RST_JUMP_LIMIT;
      cfg_r.worsen_margin    <= RST_WORSEN_MARG;
      cfg_r.retry_offset     <= RST_RETRY_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEARCH_DOWN:  cfg_r.search_down      <= cfg_wdata[0];
        CFG_START_TRIM:   cfg_r.start_trim       <= cfg_wdata[TRIM_W-1:0];
        CFG_COARSE_THR:   cfg_r.coarse_threshold <= cfg_wdata[ERR_W-1:0];
        CFG_JUMP_LIMIT:   cfg_r.jump_limit       <= cfg_wdata[ERR_W-1:0];
        CFG_WORSEN_MARG:  cfg_r.worsen_margin    <= cfg_wdata[ERR_W-1:0];
        CFG_RETRY_OFFSET: cfg_r.retry_offset     <= cfg_wdata[TRIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or its word moves on this cycle
  assign out_rdy     = !out_v_r || out_ch.ready;
  assign s2_rdy      = !s2_v_r || out_rdy;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Hold payload until the next stage takes it
  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      s1_cmd_r <= in_ch.cmd;
      s1_sum_r <= in_ch.meas_sum;
    end
    if (s2_rdy && s1_v_r) begin
      s2_cmd_r <= s1_cmd_r;
    end
    if (out_rdy && s2_v_r) begin
      out_res_r <= res_nxt;
    end
  end

  ots_err_unit u_err (
    .clk      (clk),
    .en       (s2_rdy && s1_v_r),
    .meas_sum (s1_sum_r),
    .err      (err)
  );

  // Advance the search only when its result word enters the output register
  ots_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (out_rdy && s2_v_r),
    .cmd     (s2_cmd_r),
    .err     (err),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  assign out_ch.valid       = out_v_r;
  assign out_ch.trim        = out_res_r.trim;
  assign out_ch.done_res    = out_res_r.done_res;
  assign out_ch.final_error = out_res_r.final_error;
  assign out_ch.status      = out_res_r.status;

  // A stage-two word with room ahead must show up at the output next cycle
  `OTS_ASSERT_NEXT(a_s2_to_out, s2_v_r && out_rdy, out_v_r)
  // Done flag agrees with the status code
  `OTS_ASSERT_NOW(a_done_status, out_v_r, out_res_r.done_res == (out_res_r.status != STAT_SEARCH))
  // Final error only carried by a finished search
  `OTS_ASSERT_NOW(a_err_finished, out_v_r && out_res_r.status != STAT_FINISHED, out_res_r.final_error == '0)

endmodule

// ----- hdl/ots_err_unit.sv -----
// Error magnitude stage: |meas_sum| / 10 by reciprocal multiplication.
// Depends on ots_pkg; result is registered.
module ots_err_unit import ots_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] meas_sum,
  output logic [ERR_W-1:0] err
);

  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [ERR_W-1:0]  err_r;

  // two's complement negate; the most negative word maps onto itself, as wanted
  assign mag  = meas_sum[SUM_W-1] ? (~meas_sum + 1'b1) : meas_sum;
  assign prod = {{SUM_W{1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= prod[RECIP_SHIFT+ERR_W-1:RECIP_SHIFT];
    end
  end

  assign err = err_r;

endmodule

// ----- hdl/ots_search.sv -----
// Search sequencer: holds trim, phase and best errors, steps once per word.
// Depends on ots_pkg; result fields follow the updated state.
module ots_search import ots_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             cmd,
  input  logic [ERR_W-1:0] err,
  input  cfg_t             cfg,
  output res_t             res_nxt
);

  phase_t            phase_r, phase_nxt;
  logic [TRIM_W-1:0] trim_r, trim_nxt;
  logic [ERR_W-1:0]  best_r, best_nxt;
  logic [TRIM_W-1:0] first_trim_r, first_trim_nxt;
  logic [ERR_W-1:0]  first_err_r, first_err_nxt;
  logic              dir_r, dir_nxt;

  logic              adv_ok;
  logic [TRIM_W-1:0] adv_trim;
  logic [TRIM_W-1:0] back;
  logic [TRIM_W:0]   retry_sum;
  logic [TRIM_W:0]   retry_diff;
  logic              retry_ok;
  logic [TRIM_W-1:0] retry_trim;
  logic [ERR_W:0]    jump_sum;
  logic [ERR_W:0]    margin_sum;
  logic [ERR_W:0]    err_x;

  // one step in the walk direction, and the trim one step back
  assign adv_ok     = dir_r ? (trim_r != '0) : (trim_r != '1);
  assign adv_trim   = dir_r ? (trim_r - 1'b1) : (trim_r + 1'b1);
  assign back       = dir_r ? (trim_r + 1'b1) : (trim_r - 1'b1);
  assign retry_sum  = {1'b0, back} + {1'b0, cfg.retry_offset};
  assign retry_diff = {1'b0, back} - {1'b0, cfg.retry_offset};
  assign retry_ok   = dir_r ? !retry_diff[TRIM_W] : !retry_sum[TRIM_W];
  assign retry_trim = dir_r ? retry_diff[TRIM_W-1:0] : retry_sum[TRIM_W-1:0];
  assign jump_sum   = {1'b0, best_r} + {1'b0, cfg.jump_limit};
  assign margin_sum = {1'b0, best_r} + {1'b0, cfg.worsen_margin};
  assign err_x      = {1'b0, err};

  always_comb begin
    phase_nxt      = phase_r;
    trim_nxt       = trim_r;
    best_nxt       = best_r;
    first_trim_nxt = first_trim_r;
    first_err_nxt  = first_err_r;
    dir_nxt        = dir_r;
    if (!cmd) begin
      trim_nxt       = cfg.start_trim;
      dir_nxt        = cfg.search_down;
      best_nxt       = '0;
      first_trim_nxt = '0;
      first_err_nxt  = '0;
      phase_nxt      = PH_COARSE;
    end else begin
      unique case (phase_r)
        PH_COARSE: begin
          if (err <= cfg.coarse_threshold) begin
            phase_nxt = PH_W1S;
          end else if (adv_ok) begin
            trim_nxt = adv_trim;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_W1S, PH_W2S: begin
          best_nxt = err;
          if (!adv_ok) begin
            phase_nxt = PH_FAIL;
          end else begin
            trim_nxt  = adv_trim;
            phase_nxt = (phase_r == PH_W1S) ? PH_W1 : PH_W2;
          end
        end
        PH_W1, PH_W2: begin
          priority if (err_x > jump_sum || err_x <= margin_sum) begin
            // glitch skipped, or error still close enough: keep walking
            if (err_x <= jump_sum) begin
              best_nxt = err;
            end
            if (adv_ok) begin
              trim_nxt = adv_trim;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end else if (phase_r == PH_W1) begin
            first_trim_nxt = back;
            first_err_nxt  = best_r;
            if (retry_ok) begin
              trim_nxt  = retry_trim;
              dir_nxt   = !dir_r;
              phase_nxt = PH_W2S;
            end else begin
              trim_nxt  = back;
              phase_nxt = PH_FAIL;
            end
          end else begin
            if (best_r < first_err_r) begin
              trim_nxt = back;
            end else begin
              trim_nxt = first_trim_r;
              best_nxt = first_err_r;
            end
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          // idle, done and failed ignore measurements
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.trim = trim_nxt;
    unique case (phase_nxt)
      PH_DONE: begin
        res_nxt.done_res    = 1'b1;
        res_nxt.final_error = best_nxt;
        res_nxt.status      = STAT_FINISHED;
      end
      PH_FAIL: begin
        res_nxt.done_res    = 1'b1;
        res_nxt.final_error = '0;
        res_nxt.status      = STAT_FAILED;
      end
      default: begin
        res_nxt.done_res    = 1'b0;
        res_nxt.final_error = '0;
        res_nxt.status      = STAT_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      trim_r       <= '0;
      best_r       <= '0;
      first_trim_r <= '0;
      first_err_r  <= '0;
      dir_r        <= 1'b0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      trim_r       <= trim_nxt;
      best_r       <= best_nxt;
      first_trim_r <= first_trim_nxt;
      first_err_r  <= first_err_nxt;
      dir_r        <= dir_nxt;
    end
  end

endmodule
